[src/tss_pkg.sv]
// Shared constants, codes and types for the tabulated spectrum sampler.
`default_nettype none
package tss_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int CFG_IDX_W   = 8;

  localparam logic [2:0] MODE_CDF    = 3'd0;
  localparam logic [2:0] MODE_LINES  = 3'd1;
  localparam logic [2:0] MODE_HIST   = 3'd2;
  localparam logic [2:0] MODE_INTERP = 3'd3;
  localparam logic [2:0] MODE_RANGE  = 3'd4;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_LOW  = 2'd1;
  localparam logic [1:0] ST_HIGH = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COUNT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_EMIN  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_EMAX  = CFG_IDX_W'(3);

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCAN_RD,
    OP_SCAN_TEST,
    OP_CLAMP,
    OP_FETCH_A,
    OP_FETCH_B,
    OP_FETCH_C,
    OP_FRAC_U1,
    OP_FRAC_U2,
    OP_FRAC_ZERO,
    OP_FRAC_ONE,
    OP_FRAC_QUO,
    OP_CDF_DIV_INIT,
    OP_R_DIV_INIT,
    OP_DIV_STEP,
    OP_MUL_FA_SQ,
    OP_MUL_FB_SQ,
    OP_SQ_SAVE,
    OP_MUL_LO_W1,
    OP_MUL_HI_W1,
    OP_MUL_LO_U2,
    OP_MUL_HI_U2,
    OP_ACC_SHR,
    OP_ACC_FULL,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_MUL_R,
    OP_LERP_MUL,
    OP_FIN_LERP,
    OP_FIN_LINE,
    OP_FIN_ZERO
  } dp_op_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       hit;
    logic       k_last;
    logic       den_zero;
    logic       num_ge_den;
    logic       pa_eq_pb;
    logic       c_zero;
    logic       r_sat;
  } dp_stat_t;

endpackage
`default_nettype wire

[src/tss_if.sv]
// Channel interfaces: sample/write items, results and configuration writes.
`default_nettype none
interface tss_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [7:0]  entry_index;
  logic [31:0] entry_probability;
  logic [31:0] entry_energy;
  logic [31:0] uniform_first;
  logic [31:0] uniform_second;
  modport source (output valid, command, entry_index, entry_probability, entry_energy,
                  uniform_first, uniform_second, input ready);
  modport sink (input valid, command, entry_index, entry_probability, entry_energy,
                uniform_first, uniform_second, output ready);
endinterface

interface tss_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] energy;
  logic [1:0]  status;
  modport source (output valid, energy, status, input ready);
  modport sink (input valid, energy, status, output ready);
endinterface

interface tss_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[src/tss_datapath.sv]
// Datapath: table memories, config registers, shared multiplier, divider and square root.
`default_nettype none
module tss_datapath
  import tss_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire dp_op_t         op,
  output      dp_stat_t       stat,
  input  wire logic           cfg_we,
  input  wire logic [7:0]     cfg_index,
  input  wire logic [31:0]    cfg_data,
  input  wire logic           command,
  input  wire logic [7:0]     entry_index,
  input  wire logic [31:0]    entry_probability,
  input  wire logic [31:0]    entry_energy,
  input  wire logic [31:0]    uniform_first,
  input  wire logic [31:0]    uniform_second,
  output      logic [31:0]    energy,
  output      logic [1:0]     status
);

  logic [31:0] ptab [TABLE_DEPTH];
  logic [31:0] etab [TABLE_DEPTH];
  logic [31:0] p_rd, e_rd;

  logic [2:0]       mode;
  logic [8:0]       ecount;
  logic [31:0]      emin, emax;

  logic [31:0]      u1, u2;
  logic [CNT_W-1:0] k;
  logic [ADDR_W-1:0] base;
  logic             lo_min;
  logic [1:0]       st;
  logic [31:0]      pa, pb, ea, eb;
  logic [64:0]      prod;
  logic [63:0]      sq, acc;
  logic [63:0]      sx, sres, sbit;
  logic [32:0]      rem, divisor;
  logic [31:0]      dvd_lo, quo;
  logic [32:0]      frac;

  logic [CNT_W-1:0]  n_use;
  logic [ADDR_W-1:0] idx_c, base_c, rd_addr;
  logic [1:0]        st_c;
  logic [31:0]       num, den;
  logic [31:0]       lerp_lo, lerp_hi, diff;
  logic [31:0]       mul_a;
  logic [32:0]       mul_b, w1, c_sum;
  logic [33:0]       shifted;
  logic              div_ge;
  logic [63:0]       s_try;

  always_comb begin
    if (ecount < 9'd2) begin
      n_use = CNT_W'(2);
    end else if (32'(ecount) > TABLE_DEPTH) begin
      n_use = CNT_W'(TABLE_DEPTH);
    end else begin
      n_use = CNT_W'(ecount);
    end
  end

  // Index clamp after the scan; k equals n_use when no entry matched.
  always_comb begin
    st_c = ST_OK;
    if (mode == MODE_CDF) begin
      if (k == '0) begin
        idx_c = '0;
        st_c  = ST_LOW;
      end else if (k == n_use) begin
        idx_c = ADDR_W'(n_use - CNT_W'(2));
        st_c  = ST_HIGH;
      end else begin
        idx_c = ADDR_W'(k - CNT_W'(1));
      end
    end else if (mode == MODE_INTERP) begin
      if (k > n_use - CNT_W'(2)) begin
        idx_c = ADDR_W'(n_use - CNT_W'(2));
        st_c  = ST_HIGH;
      end else begin
        idx_c = ADDR_W'(k);
      end
    end else begin
      if (k > n_use - CNT_W'(1)) begin
        idx_c = ADDR_W'(n_use - CNT_W'(1));
        st_c  = ST_HIGH;
      end else begin
        idx_c = ADDR_W'(k);
      end
    end
    base_c = (mode == MODE_HIST && idx_c != '0) ? idx_c - ADDR_W'(1) : idx_c;
  end

  always_comb begin
    unique case (op)
      OP_FETCH_A: rd_addr = base;
      OP_FETCH_B: rd_addr = base + ADDR_W'(1);
      default:    rd_addr = ADDR_W'(k);
    endcase
  end

  assign num = (u1 > pa) ? u1 - pa : 32'd0;
  assign den = (pb > pa) ? pb - pa : 32'd0;

  assign lerp_lo = (mode == MODE_RANGE || lo_min) ? emin : ea;
  assign lerp_hi = (mode == MODE_RANGE) ? emax : (lo_min ? ea : eb);
  assign diff    = (lerp_hi >= lerp_lo) ? lerp_hi - lerp_lo : lerp_lo - lerp_hi;

  assign w1    = 33'h1_0000_0000 - {1'b0, u2};
  assign c_sum = {1'b0, sres[31:0]} + {1'b0, pa};

  always_comb begin
    unique case (op)
      OP_MUL_FA_SQ: begin mul_a = pa;         mul_b = {1'b0, pa}; end
      OP_MUL_FB_SQ: begin mul_a = pb;         mul_b = {1'b0, pb}; end
      OP_MUL_LO_W1: begin mul_a = sq[31:0];   mul_b = w1; end
      OP_MUL_HI_W1: begin mul_a = sq[63:32];  mul_b = w1; end
      OP_MUL_LO_U2: begin mul_a = sq[31:0];   mul_b = {1'b0, u2}; end
      OP_MUL_HI_U2: begin mul_a = sq[63:32];  mul_b = {1'b0, u2}; end
      OP_MUL_R:     begin mul_a = u2;         mul_b = {1'b0, pa} + {1'b0, pb}; end
      default:      begin mul_a = diff;       mul_b = frac; end
    endcase
  end

  assign shifted = {rem, dvd_lo[31]};
  assign div_ge  = shifted >= {1'b0, divisor};
  assign s_try   = sres + sbit;

  assign stat.mode       = mode;
  assign stat.hit        = (mode == MODE_CDF) ? (p_rd >= u1) : (u1 < p_rd);
  assign stat.k_last     = (k == n_use - CNT_W'(1));
  assign stat.den_zero   = (den == 32'd0);
  assign stat.num_ge_den = (num >= den);
  assign stat.pa_eq_pb   = (pa == pb);
  assign stat.c_zero     = (c_sum == 33'd0);
  assign stat.r_sat      = (prod[64:32] >= c_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_CDF;
      ecount <= 9'd2;
      emin   <= '0;
      emax   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:  mode   <= cfg_data[2:0];
        REG_COUNT: ecount <= cfg_data[8:0];
        REG_EMIN:  emin   <= cfg_data;
        REG_EMAX:  emax   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_LOAD && command == CMD_WRITE && 32'(entry_index) < TABLE_DEPTH) begin
      ptab[ADDR_W'(entry_index)] <= entry_probability;
      etab[ADDR_W'(entry_index)] <= entry_energy;
    end
    p_rd <= ptab[rd_addr];
    e_rd <= etab[rd_addr];
  end

  always_ff @(posedge clk) begin
    unique case (op)
      OP_LOAD: begin
        u1     <= uniform_first;
        u2     <= uniform_second;
        k      <= '0;
        st     <= ST_OK;
        lo_min <= 1'b0;
      end
      OP_SCAN_TEST: if (!stat.hit) k <= k + CNT_W'(1);
      OP_CLAMP: begin
        base   <= base_c;
        st     <= st_c;
        lo_min <= (mode == MODE_HIST) && (idx_c == '0);
      end
      OP_FETCH_B: begin pa <= p_rd; ea <= e_rd; end
      OP_FETCH_C: begin pb <= p_rd; eb <= e_rd; end
      OP_FRAC_U1:   frac <= {1'b0, u1};
      OP_FRAC_U2:   frac <= {1'b0, u2};
      OP_FRAC_ZERO: frac <= '0;
      OP_FRAC_ONE:  frac <= 33'h1_0000_0000;
      OP_FRAC_QUO:  frac <= {1'b0, quo};
      OP_CDF_DIV_INIT: begin
        rem     <= {1'b0, num};
        divisor <= {1'b0, den};
        dvd_lo  <= '0;
        quo     <= '0;
      end
      OP_R_DIV_INIT: begin
        rem     <= prod[64:32];
        divisor <= c_sum;
        dvd_lo  <= prod[31:0];
        quo     <= '0;
      end
      OP_DIV_STEP: begin
        rem    <= div_ge ? 33'(shifted - {1'b0, divisor}) : shifted[32:0];
        quo    <= {quo[30:0], div_ge};
        dvd_lo <= {dvd_lo[30:0], 1'b0};
      end
      OP_MUL_FA_SQ: begin
        prod <= mul_a * mul_b;
        acc  <= '0;
      end
      OP_MUL_FB_SQ, OP_MUL_LO_W1, OP_MUL_HI_W1, OP_MUL_LO_U2, OP_MUL_HI_U2,
      OP_MUL_R, OP_LERP_MUL: prod <= mul_a * mul_b;
      OP_SQ_SAVE:  sq  <= prod[63:0];
      OP_ACC_SHR:  acc <= acc + {31'd0, prod[64:32]};
      OP_ACC_FULL: acc <= acc + prod[63:0];
      OP_SQRT_INIT: begin
        sx   <= acc;
        sres <= '0;
        sbit <= 64'h4000_0000_0000_0000;
      end
      OP_SQRT_STEP: begin
        if (sx >= s_try) begin
          sx   <= sx - s_try;
          sres <= (sres >> 1) + sbit;
        end else begin
          sres <= sres >> 1;
        end
        sbit <= sbit >> 2;
      end
      OP_FIN_LERP: begin
        energy <= (lerp_hi >= lerp_lo) ? lerp_lo + prod[63:32] : lerp_lo - prod[63:32];
        status <= st;
      end
      OP_FIN_LINE: begin
        energy <= ea;
        status <= st;
      end
      OP_FIN_ZERO: begin
        energy <= '0;
        status <= ST_OK;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[src/tss_ctrl.sv]
// Controller: sequences scan, fetch, arithmetic and result handoff for one item.
`default_nettype none
module tss_ctrl
  import tss_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     item_valid,
  input  wire logic     item_command,
  output      logic     item_ready,
  output      logic     result_valid,
  input  wire logic     result_ready,
  input  wire dp_stat_t stat,
  output      dp_op_t   op
);

  typedef enum logic [5:0] {
    S_IDLE, S_DISPATCH, S_SCAN_RD, S_SCAN_TEST, S_CLAMP, S_FETCH_A, S_FETCH_B,
    S_FETCH_C, S_BRANCH, S_SET_U1, S_SET_U2, S_SET_ZERO, S_SET_ONE, S_SET_QUO,
    S_CDF_INIT, S_DIV_STEP, S_MUL_FA, S_SAVE_A, S_LO_W1, S_SHR_A, S_HI_W1,
    S_FULL_A, S_MUL_FB, S_SAVE_B, S_LO_U2, S_SHR_B, S_HI_U2, S_FULL_B,
    S_SQRT_INIT, S_SQRT_STEP, S_MUL_R, S_R_CHECK, S_R_INIT, S_LERP_MUL, S_FIN
  } state_t;

  state_t     state;
  logic [4:0] cnt;
  dp_op_t     fin_op;
  logic       fin_go;

  assign item_ready = (state == S_IDLE);
  assign fin_go     = (state == S_FIN) && (!result_valid || result_ready);

  always_comb begin
    unique case (state)
      S_IDLE:      op = (item_valid) ? OP_LOAD : OP_NONE;
      S_SCAN_RD:   op = OP_SCAN_RD;
      S_SCAN_TEST: op = OP_SCAN_TEST;
      S_CLAMP:     op = OP_CLAMP;
      S_FETCH_A:   op = OP_FETCH_A;
      S_FETCH_B:   op = OP_FETCH_B;
      S_FETCH_C:   op = OP_FETCH_C;
      S_SET_U1:    op = OP_FRAC_U1;
      S_SET_U2:    op = OP_FRAC_U2;
      S_SET_ZERO:  op = OP_FRAC_ZERO;
      S_SET_ONE:   op = OP_FRAC_ONE;
      S_SET_QUO:   op = OP_FRAC_QUO;
      S_CDF_INIT:  op = OP_CDF_DIV_INIT;
      S_DIV_STEP:  op = OP_DIV_STEP;
      S_MUL_FA:    op = OP_MUL_FA_SQ;
      S_SAVE_A, S_SAVE_B: op = OP_SQ_SAVE;
      S_LO_W1:     op = OP_MUL_LO_W1;
      S_HI_W1:     op = OP_MUL_HI_W1;
      S_SHR_A, S_SHR_B:   op = OP_ACC_SHR;
      S_FULL_A, S_FULL_B: op = OP_ACC_FULL;
      S_MUL_FB:    op = OP_MUL_FB_SQ;
      S_LO_U2:     op = OP_MUL_LO_U2;
      S_HI_U2:     op = OP_MUL_HI_U2;
      S_SQRT_INIT: op = OP_SQRT_INIT;
      S_SQRT_STEP: op = OP_SQRT_STEP;
      S_MUL_R:     op = OP_MUL_R;
      S_R_INIT:    op = OP_R_DIV_INIT;
      S_LERP_MUL:  op = OP_LERP_MUL;
      S_FIN:       op = fin_go ? fin_op : OP_NONE;
      default:     op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      cnt          <= '0;
      fin_op       <= OP_FIN_ZERO;
    end else begin
      if (fin_go) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: if (item_valid && item_command == CMD_SAMPLE) state <= S_DISPATCH;
        S_DISPATCH: begin
          fin_op <= OP_FIN_LERP;
          if (stat.mode == MODE_CDF || stat.mode == MODE_LINES ||
              stat.mode == MODE_HIST || stat.mode == MODE_INTERP) begin
            state <= S_SCAN_RD;
          end else if (stat.mode == MODE_RANGE) begin
            state <= S_SET_U1;
          end else begin
            fin_op <= OP_FIN_ZERO;
            state  <= S_FIN;
          end
        end
        S_SCAN_RD:   state <= S_SCAN_TEST;
        S_SCAN_TEST: state <= (stat.hit || stat.k_last) ? S_CLAMP : S_SCAN_RD;
        S_CLAMP:     state <= S_FETCH_A;
        S_FETCH_A:   state <= S_FETCH_B;
        S_FETCH_B:   state <= S_FETCH_C;
        S_FETCH_C:   state <= S_BRANCH;
        S_BRANCH: begin
          priority if (stat.mode == MODE_LINES) begin
            fin_op <= OP_FIN_LINE;
            state  <= S_FIN;
          end else if (stat.mode == MODE_HIST) begin
            state <= S_SET_U2;
          end else if (stat.mode == MODE_CDF) begin
            if (stat.den_zero)        state <= S_SET_ZERO;
            else if (stat.num_ge_den) state <= S_SET_ONE;
            else                      state <= S_CDF_INIT;
          end else begin
            state <= stat.pa_eq_pb ? S_SET_U2 : S_MUL_FA;
          end
        end
        S_SET_U1, S_SET_U2, S_SET_ZERO, S_SET_ONE, S_SET_QUO: state <= S_LERP_MUL;
        S_CDF_INIT, S_R_INIT: begin
          cnt   <= '0;
          state <= S_DIV_STEP;
        end
        S_DIV_STEP: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) state <= S_SET_QUO;
        end
        S_MUL_FA:    state <= S_SAVE_A;
        S_SAVE_A:    state <= S_LO_W1;
        S_LO_W1:     state <= S_SHR_A;
        S_SHR_A:     state <= S_HI_W1;
        S_HI_W1:     state <= S_FULL_A;
        S_FULL_A:    state <= S_MUL_FB;
        S_MUL_FB:    state <= S_SAVE_B;
        S_SAVE_B:    state <= S_LO_U2;
        S_LO_U2:     state <= S_SHR_B;
        S_SHR_B:     state <= S_HI_U2;
        S_HI_U2:     state <= S_FULL_B;
        S_FULL_B:    state <= S_SQRT_INIT;
        S_SQRT_INIT: begin
          cnt   <= '0;
          state <= S_SQRT_STEP;
        end
        S_SQRT_STEP: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) state <= S_MUL_R;
        end
        S_MUL_R:     state <= S_R_CHECK;
        S_R_CHECK: begin
          if (stat.c_zero)     state <= S_SET_ZERO;
          else if (stat.r_sat) state <= S_SET_ONE;
          else                 state <= S_R_INIT;
        end
        S_LERP_MUL:  state <= S_FIN;
        S_FIN:       if (fin_go) state <= S_IDLE;
        default:     state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[src/tabulated_spectrum_sampler_core.sv]
// A write item is taken without leaving idle; a sample scans the table linearly,
// visiting m entries, where m runs from 1 to entry_count (clamped to 2..256);
// range mode skips the scan.
// The interpolated mode adds 12 multiply steps, 32 root steps and 32 divide steps.
// Throughput: one item at a time; a finished result waits in the output register
// while the next item is taken. Synchronous reset clears control and config;
// table contents are undefined until written.
`default_nettype none
module tabulated_spectrum_sampler_core
  import tss_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  tss_in_if.sink   item,
  tss_out_if.source result,
  tss_cfg_if.sink  cfg
);

  dp_op_t   op;
  dp_stat_t stat;

  assign cfg.ready = 1'b1;

  tss_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_command (item.command),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .stat         (stat),
    .op           (op)
  );

  tss_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .op                (op),
    .stat              (stat),
    .cfg_we            (cfg.valid),
    .cfg_index         (cfg.index),
    .cfg_data          (cfg.data),
    .command           (item.command),
    .entry_index       (item.entry_index),
    .entry_probability (item.entry_probability),
    .entry_energy      (item.entry_energy),
    .uniform_first     (item.uniform_first),
    .uniform_second    (item.uniform_second),
    .energy            (result.energy),
    .status            (result.status)
  );

endmodule
`default_nettype wire

[src/tss_checker.sv]
// Port-level checks for the sampler core, bound to the top level.
`default_nettype none
module tss_checker
  import tss_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        item_valid,
  input wire logic        item_ready,
  input wire logic        item_command,
  input wire logic        result_valid,
  input wire logic        result_ready,
  input wire logic [31:0] result_energy,
  input wire logic [1:0]  result_status
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result dropped before transfer");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(result_energy) && $stable(result_status))
    else $error("result payload changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result_status != 2'd3)
    else $error("illegal status code");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  a_busy_after_sample: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item_command == CMD_SAMPLE |=> !item_ready)
    else $error("new item taken while a sample is in work");

endmodule

bind tabulated_spectrum_sampler_core tss_checker u_tss_checker (
  .clk           (clk),
  .rst           (rst),
  .item_valid    (item.valid),
  .item_ready    (item.ready),
  .item_command  (item.command),
  .result_valid  (result.valid),
  .result_ready  (result.ready),
  .result_energy (result.energy),
  .result_status (result.status)
);
`default_nettype wire
